FILE: rtl/sam_pkg.sv
// shared types and constants for the suffix automaton substring checker
`default_nettype none
package sam_pkg;

	// default sizing
	localparam int MAX_TEXT_DEF = 1024;
	localparam int ALPHABET_DEF = 256;

	// request type codes
	localparam logic REQ_APPEND = 1'b0;
	localparam logic REQ_QUERY  = 1'b1;

	// one result item
	typedef struct packed {
		logic answer_valid;
		logic is_match;
		logic full_error;
	} result_t;

	// engine sequencer states
	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_Q_RD,
		ST_Q_CHK,
		ST_A_RD,
		ST_A_CHK,
		ST_A_CLR,
		ST_W_RD,
		ST_W_CHK,
		ST_L_RD,
		ST_L_CHK,
		ST_COPY,
		ST_C_END,
		ST_LNK,
		ST_R_RD,
		ST_R_CHK,
		ST_FIN,
		ST_RESP
	} eng_state_t;

endpackage
`default_nettype wire

FILE: rtl/suffix_automaton_substring_check_core.sv
// top level of the suffix automaton substring checker
// Use: each request carries req_type, symbol and word_last on the req channel
// (req_valid / req_stall); each request yields exactly one result on the rsp
// channel (rsp_valid / rsp_stall) with answer_valid, is_match and full_error.
// Appends build the automaton of the text; query symbols walk it and the
// request marked word_last reports whether the word is a substring.
// A query step reads one transition, or none once its word has failed. An
// append clears the new state's row, walks the suffix links reading one
// transition per state, reads the target's length when the walk stops at an
// existing transition, and on a clone copies that row and walks the redirects.
// The row clear of each new state and the row copy of a clone, one entry a
// cycle through the transition memory port, set the append cost. Dropped
// appends skip to the result. The result is registered as req_stall falls.
// One request is in work at a time; req_stall is high until the result has
// been placed in the output register, which can hold it while rsp_stall is
// high and the next request is already being worked on.
// Reset: after arst_n releases, the root row of the transition memory is
// cleared in a sweep of ALPHABET cycles, with req_stall high throughout.
`default_nettype none
module suffix_automaton_substring_check_core #(
	parameter int MAX_TEXT = sam_pkg::MAX_TEXT_DEF,
	parameter int ALPHABET = sam_pkg::ALPHABET_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       req_valid,
	output logic            req_stall,
	input  wire logic       req_type,
	input  wire logic [7:0] symbol,
	input  wire logic       word_last,
	output logic            rsp_valid,
	input  wire logic       rsp_stall,
	output logic            answer_valid,
	output logic            is_match,
	output logic            full_error
);

	logic             eng_ready, eng_done, slot_free;
	sam_pkg::result_t eng_res;
	logic             rsp_valid_q;
	sam_pkg::result_t rsp_q;

	assign req_stall = !eng_ready;
	assign slot_free = !rsp_valid_q || !rsp_stall;

	sam_engine #(
		.MAX_TEXT (MAX_TEXT),
		.ALPHABET (ALPHABET)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (req_valid && eng_ready),
		.req_type  (req_type),
		.symbol    (symbol),
		.word_last (word_last),
		.slot_free (slot_free),
		.ready     (eng_ready),
		.done      (eng_done),
		.res       (eng_res)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_done) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_done) begin
			rsp_q <= eng_res;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign answer_valid = rsp_q.answer_valid;
	assign is_match     = rsp_q.is_match;
	assign full_error   = rsp_q.full_error;

endmodule
`default_nettype wire

FILE: rtl/sam_engine.sv
// automaton store and sequencer: appends, clones, redirects and query steps
`default_nettype none
module sam_engine #(
	parameter int MAX_TEXT = sam_pkg::MAX_TEXT_DEF,
	parameter int ALPHABET = sam_pkg::ALPHABET_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic             req_type,
	input  wire logic [7:0]       symbol,
	input  wire logic             word_last,
	input  wire logic             slot_free,
	output logic                  ready,
	output logic                  done,
	output sam_pkg::result_t      res
);

	localparam int STATES = 2 * MAX_TEXT;
	localparam int SW     = $clog2(STATES);
	localparam int LW     = $clog2(MAX_TEXT + 1);
	localparam int CW     = $clog2(MAX_TEXT + 1);
	localparam int AW     = $clog2(ALPHABET);
	localparam int TDEPTH = STATES * ALPHABET;
	localparam int TW     = $clog2(TDEPTH);
	localparam int IW     = LW + SW;

	// flat address of one transition entry
	function automatic logic [TW-1:0] taddr(input logic [SW-1:0] s, input logic [AW-1:0] a);
		return TW'(s) * TW'(ALPHABET) + TW'(a);
	endfunction

	sam_pkg::eng_state_t state_q, state_d;

	logic [AW-1:0] cnt_q;
	logic [AW-1:0] c_q;
	logic          wl_q;
	logic [SW-1:0] p_q, q_q, cur_q, cl_q, last_q, sc_q, qs_q;
	logic [LW-1:0] cur_len_q, len_p_q, len_q_q;
	logic [CW-1:0] tc_q;
	logic          failed_q;
	sam_pkg::result_t res_q;

	// memories
	logic [SW-1:0] trans_mem [TDEPTH];
	logic [IW-1:0] info_mem [STATES];
	logic          trans_we, info_we;
	logic [TW-1:0] trans_waddr, trans_raddr;
	logic [SW-1:0] trans_wdata, trans_rd;
	logic [SW-1:0] info_waddr, info_raddr;
	logic [IW-1:0] info_wdata, info_rd;

	logic [LW-1:0] rd_len;
	logic [SW-1:0] rd_link;
	logic          in_alpha;
	logic          cnt_end;

	assign rd_len   = info_rd[IW-1:SW];
	assign rd_link  = info_rd[SW-1:0];
	assign in_alpha = ({1'b0, symbol} < 9'(ALPHABET));
	assign cnt_end  = (cnt_q == AW'(ALPHABET - 1));

	// transition store
	always_ff @(posedge clk) begin
		if (trans_we) begin
			trans_mem[trans_waddr] <= trans_wdata;
		end
		trans_rd <= trans_mem[trans_raddr];
	end

	// length and suffix link store
	always_ff @(posedge clk) begin
		if (info_we) begin
			info_mem[info_waddr] <= info_wdata;
		end
		info_rd <= info_mem[info_raddr];
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			sam_pkg::ST_INIT: if (cnt_end) state_d = sam_pkg::ST_IDLE;
			sam_pkg::ST_IDLE: begin
				if (start) begin
					if (req_type == sam_pkg::REQ_QUERY) begin
						state_d = (!failed_q && in_alpha) ? sam_pkg::ST_Q_RD : sam_pkg::ST_RESP;
					end else if (tc_q >= CW'(MAX_TEXT) || !in_alpha) begin
						state_d = sam_pkg::ST_RESP;
					end else begin
						state_d = sam_pkg::ST_A_RD;
					end
				end
			end
			sam_pkg::ST_Q_RD:  state_d = sam_pkg::ST_Q_CHK;
			sam_pkg::ST_Q_CHK: state_d = sam_pkg::ST_RESP;
			sam_pkg::ST_A_RD:  state_d = sam_pkg::ST_A_CHK;
			sam_pkg::ST_A_CHK: state_d = sam_pkg::ST_A_CLR;
			sam_pkg::ST_A_CLR: if (cnt_end) state_d = sam_pkg::ST_W_RD;
			sam_pkg::ST_W_RD:  state_d = sam_pkg::ST_W_CHK;
			sam_pkg::ST_W_CHK: begin
				if (trans_rd == '0) begin
					state_d = (p_q == '0) ? sam_pkg::ST_FIN : sam_pkg::ST_W_RD;
				end else begin
					state_d = sam_pkg::ST_L_RD;
				end
			end
			sam_pkg::ST_L_RD:  state_d = sam_pkg::ST_L_CHK;
			sam_pkg::ST_L_CHK: begin
				state_d = ((len_p_q + LW'(1)) == rd_len) ? sam_pkg::ST_FIN : sam_pkg::ST_COPY;
			end
			sam_pkg::ST_COPY:  if (cnt_end) state_d = sam_pkg::ST_C_END;
			sam_pkg::ST_C_END: state_d = sam_pkg::ST_LNK;
			sam_pkg::ST_LNK:   state_d = sam_pkg::ST_R_RD;
			sam_pkg::ST_R_RD:  state_d = sam_pkg::ST_R_CHK;
			sam_pkg::ST_R_CHK: begin
				if (trans_rd == q_q && p_q != '0) begin
					state_d = sam_pkg::ST_R_RD;
				end else begin
					state_d = sam_pkg::ST_FIN;
				end
			end
			sam_pkg::ST_FIN:   state_d = sam_pkg::ST_RESP;
			sam_pkg::ST_RESP:  if (slot_free) state_d = sam_pkg::ST_IDLE;
			default:           state_d = sam_pkg::ST_INIT;
		endcase
	end

	// memory ports and handshake outputs
	always_comb begin
		trans_we    = 1'b0;
		trans_waddr = taddr(p_q, c_q);
		trans_wdata = '0;
		trans_raddr = taddr(p_q, c_q);
		info_we     = 1'b0;
		info_waddr  = cur_q;
		info_wdata  = '0;
		info_raddr  = p_q;
		ready       = (state_q == sam_pkg::ST_IDLE);
		done        = (state_q == sam_pkg::ST_RESP) && slot_free;
		res         = res_q;
		unique case (state_q)
			sam_pkg::ST_INIT: begin
				trans_we    = 1'b1;
				trans_waddr = taddr('0, cnt_q);
				info_we     = 1'b1;
				info_waddr  = '0;
			end
			sam_pkg::ST_Q_RD: trans_raddr = taddr(qs_q, c_q);
			sam_pkg::ST_A_RD: info_raddr = last_q;
			sam_pkg::ST_A_CHK: begin
				info_we    = 1'b1;
				info_wdata = {rd_len + LW'(1), SW'(0)};
			end
			sam_pkg::ST_A_CLR: begin
				trans_we    = 1'b1;
				trans_waddr = taddr(cur_q, cnt_q);
			end
			sam_pkg::ST_W_CHK: begin
				trans_we    = (trans_rd == '0);
				trans_wdata = cur_q;
			end
			sam_pkg::ST_L_RD: info_raddr = q_q;
			sam_pkg::ST_L_CHK: begin
				info_we = 1'b1;
				if ((len_p_q + LW'(1)) == rd_len) begin
					info_wdata = {cur_len_q, q_q};
				end else begin
					info_waddr = sc_q;
					info_wdata = {len_p_q + LW'(1), rd_link};
				end
			end
			sam_pkg::ST_COPY: begin
				trans_raddr = taddr(q_q, cnt_q);
				trans_we    = (cnt_q != '0);
				trans_waddr = taddr(cl_q, cnt_q - AW'(1));
				trans_wdata = trans_rd;
			end
			sam_pkg::ST_C_END: begin
				trans_we    = 1'b1;
				trans_waddr = taddr(cl_q, AW'(ALPHABET - 1));
				trans_wdata = trans_rd;
				info_we     = 1'b1;
				info_waddr  = q_q;
				info_wdata  = {len_q_q, cl_q};
			end
			sam_pkg::ST_LNK: begin
				info_we    = 1'b1;
				info_wdata = {cur_len_q, cl_q};
			end
			sam_pkg::ST_R_CHK: begin
				trans_we    = (trans_rd == q_q);
				trans_wdata = cl_q;
			end
			default: begin
			end
		endcase
	end

	// sequencer registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= sam_pkg::ST_INIT;
			cnt_q    <= '0;
			last_q   <= '0;
			sc_q     <= SW'(1);
			tc_q     <= '0;
			qs_q     <= '0;
			failed_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				sam_pkg::ST_INIT: cnt_q <= cnt_q + AW'(1);
				sam_pkg::ST_IDLE: begin
					if (start) begin
						c_q  <= symbol[AW-1:0];
						wl_q <= word_last;
						// answer of a failed word, or a dropped append
						res_q.answer_valid <= (req_type == sam_pkg::REQ_QUERY)
							&& (failed_q || !in_alpha) && word_last;
						res_q.is_match     <= 1'b0;
						res_q.full_error   <= (req_type == sam_pkg::REQ_APPEND)
							&& (tc_q >= CW'(MAX_TEXT));
						if (req_type == sam_pkg::REQ_QUERY) begin
							if (failed_q || !in_alpha) begin
								if (word_last) begin
									qs_q     <= '0;
									failed_q <= 1'b0;
								end else begin
									failed_q <= 1'b1;
								end
							end
						end else if (tc_q < CW'(MAX_TEXT) && in_alpha) begin
							cur_q <= sc_q;
							sc_q  <= sc_q + SW'(1);
						end
					end
				end
				sam_pkg::ST_Q_CHK: begin
					if (wl_q) begin
						res_q.answer_valid <= 1'b1;
						res_q.is_match     <= (trans_rd != '0);
						qs_q               <= '0;
						failed_q           <= 1'b0;
					end else if (trans_rd == '0) begin
						failed_q <= 1'b1;
					end else begin
						qs_q <= trans_rd;
					end
				end
				sam_pkg::ST_A_CHK: begin
					cur_len_q <= rd_len + LW'(1);
					cnt_q     <= '0;
				end
				sam_pkg::ST_A_CLR: begin
					cnt_q <= cnt_q + AW'(1);
					p_q   <= last_q;
				end
				sam_pkg::ST_W_CHK: begin
					if (trans_rd == '0) begin
						p_q <= rd_link;
					end else begin
						q_q     <= trans_rd;
						len_p_q <= rd_len;
					end
				end
				sam_pkg::ST_L_CHK: begin
					cl_q    <= sc_q;
					len_q_q <= rd_len;
					cnt_q   <= '0;
					if ((len_p_q + LW'(1)) != rd_len) begin
						sc_q <= sc_q + SW'(1);
					end
				end
				sam_pkg::ST_COPY: cnt_q <= cnt_q + AW'(1);
				sam_pkg::ST_R_CHK: p_q <= rd_link;
				sam_pkg::ST_FIN: begin
					last_q <= cur_q;
					tc_q   <= tc_q + CW'(1);
				end
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire
